@@ src/sfr_pkg.sv @@
`default_nettype none

package sfr_pkg;

    localparam int FRAME_LEN   = 18;
    localparam int CHECK_POS   = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int IDX_W       = $clog2(FRAME_LEN);
    localparam int FILL_W      = $clog2(FRAME_LEN + 1);

    localparam logic [7:0] FRAME_HEAD = 8'h5B;
    localparam logic [7:0] FRAME_TAIL = 8'h5D;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic signed [15:0] linear_speed;
        logic signed [15:0] angular_speed;
        logic signed [15:0] supply_millivolts;
        logic signed [15:0] heading;
        logic signed [15:0] yaw_rate;
        logic signed [15:0] vertical_accel;
    } frame_t;

    // handshake between two stages
    typedef struct packed {
        logic   valid;
        frame_t data;
    } frame_req_t;

endpackage

`default_nettype wire

@@ src/sfr_front.sv @@
`default_nettype none

module sfr_front
    import sfr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  byte_valid,
    output logic       byte_ready,
    input  wire byte_t rx_byte,
    input  wire logic  queue_full,
    output frame_req_t push
);

    byte_t            win_reg  [FRAME_LEN];
    byte_t            win_next [FRAME_LEN];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic             full_next;
    logic             frame_ok;
    byte_t            sum;
    logic             take;

    assign byte_ready = !queue_full;
    assign take       = byte_valid && byte_ready;

    always_comb
    begin
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (fill_reg == FILL_W'(FRAME_LEN))
        begin
            for (int i = 0; i < FRAME_LEN - 1; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[FRAME_LEN - 1] = rx_byte;
        end
        else
        begin
            win_next[fill_reg[IDX_W-1:0]] = rx_byte;
        end
        full_next = (fill_reg >= FILL_W'(FRAME_LEN - 1));

        sum = '0;
        for (int i = 0; i < CHECK_POS; i++)
        begin
            sum = sum ^ win_next[i];
        end
        frame_ok = full_next && (win_next[0] == FRAME_HEAD)
                   && (win_next[FRAME_LEN - 1] == FRAME_TAIL)
                   && (sum == win_next[CHECK_POS]);

        if (frame_ok)
            fill_next = '0;
        else if (full_next)
            fill_next = FILL_W'(FRAME_LEN);
        else
            fill_next = fill_reg + 1'b1;
    end

    always_comb
    begin
        push.valid                  = take && frame_ok;
        push.data.linear_speed      = $signed({win_next[2],  win_next[3]});
        push.data.angular_speed     = $signed({win_next[6],  win_next[7]});
        push.data.supply_millivolts = $signed({win_next[8],  win_next[9]});
        push.data.heading           = $signed({win_next[10], win_next[11]});
        push.data.yaw_rate          = $signed({win_next[12], win_next[13]});
        push.data.vertical_accel    = $signed({win_next[14], win_next[15]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (take)
        begin
            fill_reg <= fill_next;
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                // accepted frame empties the window
                win_reg[i] <= frame_ok ? '0 : win_next[i];
            end
        end
    end

endmodule

`default_nettype wire

@@ src/sfr_queue.sv @@
`default_nettype none

module sfr_queue
    import sfr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire frame_req_t push,
    output logic            full,
    output frame_req_t      head,
    input  wire logic       pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.data  = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ src/sfr_back.sv @@
`default_nettype none

module sfr_back
    import sfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire frame_req_t head,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output frame_t          result
);

    logic   valid_reg;
    frame_t result_reg;

    assign pop       = head.valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign result    = result_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
            result_reg <= head.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

endmodule

`default_nettype wire

@@ src/sensor_frame_receiver.sv @@
// Serial frame receiver: finds 18-byte frames (0x5B head, 0x5D tail, XOR
// of bytes 0-15 in byte 16) in a stream of received bytes.
// Input channel in_valid/in_ready/rx_byte: one byte per request, one per
// cycle sustained while in_ready is high. Bytes slide through an 18-byte
// window; after each byte the window is checked and a passing frame
// empties it. Output channel out_valid/out_ready: one request per good
// frame with six big-endian signed 16-bit fields.
// Result path: the edge that takes the frame's last byte writes the
// queue, then the output register loads from the queue head.
// Throughput: 1 byte per cycle while in_ready is high, set by the
// window update and the 16-byte XOR tree that checks the new window in
// the same cycle. When the output side stalls, finished frames wait in a
// small queue (QUEUE_DEPTH entries) plus the output register; in_ready
// drops only while that queue is full.
// Reset clears the window, the fill count, the queue and out_valid.
`default_nettype none

module sensor_frame_receiver
    import sfr_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   rx_byte,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic signed [15:0] linear_speed,
    output logic signed [15:0] angular_speed,
    output logic signed [15:0] supply_millivolts,
    output logic signed [15:0] heading,
    output logic signed [15:0] yaw_rate,
    output logic signed [15:0] vertical_accel
);

    frame_req_t push;
    frame_req_t head;
    logic       queue_full;
    logic       pop;
    frame_t     result;

    sfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_valid),
        .byte_ready (in_ready),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .push       (push)
    );

    sfr_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .head  (head),
        .pop   (pop)
    );

    sfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign linear_speed      = result.linear_speed;
    assign angular_speed     = result.angular_speed;
    assign supply_millivolts = result.supply_millivolts;
    assign heading           = result.heading;
    assign yaw_rate          = result.yaw_rate;
    assign vertical_accel    = result.vertical_accel;

endmodule

`default_nettype wire
